// ===== hdl/prt_pkg.sv =====
// shared types, constants and the saturation function of the point transform
package prt_pkg;

	localparam int unsigned FIELD_W = 32;
	localparam int unsigned SIDE_W  = FIELD_W + 1;
	localparam int unsigned CFG_W   = 64;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned NSTAGE  = 13;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_TRIG_X  = 3'd0;
	localparam logic [IDX_W-1:0] REG_TRIG_Y  = 3'd1;
	localparam logic [IDX_W-1:0] REG_TRIG_Z  = 3'd2;
	localparam logic [IDX_W-1:0] REG_PLACE_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_PLACE_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_PLACE_Z = 3'd5;

	// cosine 1.0 in q2.30, sine zero
	localparam logic [CFG_W-1:0] TRIG_RESET  = 64'h4000_0000_0000_0000;
	localparam logic [CFG_W-1:0] PLACE_RESET = 64'h0;

	// stage enables of one rotation unit
	typedef struct packed {
		logic en_mul;
		logic en_sum;
		logic en_sat;
	} rot_ctrl_t;

	// clamp to a signed range of w bits, result sign-extended to 32 bits
	function automatic logic signed [FIELD_W-1:0] sat_coord(input logic signed [37:0] v,
			input int unsigned w);
		logic signed [37:0] hi;
		logic signed [37:0] lo;
		logic signed [37:0] r;
		hi = (38'sd1 <<< (w - 1)) - 38'sd1;
		lo = -hi - 38'sd1;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[FIELD_W-1:0];
	endfunction

endpackage

// ===== hdl/prt_if.sv =====
// point and moved-point stream interfaces

interface prt_in_if;
	logic                      valid;
	logic                      ready;
	logic signed [31:0]        in_x;
	logic signed [31:0]        in_y;
	logic signed [31:0]        in_z;
	logic                      last_point;

	modport source (output valid, output in_x, output in_y, output in_z,
		output last_point, input ready);
	modport sink (input valid, input in_x, input in_y, input in_z,
		input last_point, output ready);
endinterface

interface prt_out_if;
	logic                      valid;
	logic                      ready;
	logic signed [31:0]        out_x;
	logic signed [31:0]        out_y;
	logic signed [31:0]        out_z;
	logic                      out_last;

	modport source (output valid, output out_x, output out_y, output out_z,
		output out_last, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input out_last, output ready);
endinterface

// ===== hdl/point_rotate_translate.sv =====
// throughput: one point per cycle; a stage holds its word only while the one after it cannot move
// the three rotations each take a multiply, a round and a saturate stage
// reset: valid bits clear, rotations return to identity, pivots and targets to zero
// reset is asynchronous, active low; the pipeline data registers are not reset
module point_rotate_translate #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	prt_in_if.sink                        pts,
	prt_out_if.source                     moved,
	input  logic                          cfg_we,
	input  logic [prt_pkg::IDX_W-1:0]     cfg_index,
	input  logic [prt_pkg::CFG_W-1:0]     cfg_data
);
	import prt_pkg::*;

	logic [CFG_W-1:0] trig_x_q, trig_y_q, trig_z_q;
	logic [CFG_W-1:0] place_x_q, place_y_q, place_z_q;

	logic signed [31:0] cx, sx, cy, sy, cz, sz;
	logic signed [31:0] px, py, pz, tx, ty, tz;

	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] en;

	logic signed [32:0] dy_s1, dz_s1, dx_s5, dz_s5, dx_s9, dy_s9;
	logic [SIDE_W-1:0]  side_s1, side_s5, side_s9;
	logic [SIDE_W-1:0]  side_x, side_y, side_z;
	logic signed [31:0] ny_x, nz_x, nz_y, nx_y, nx_z, ny_z;
	logic signed [31:0] out_x_s13, out_y_s13, out_z_s13;
	logic               last_s13;

	rot_ctrl_t ctrl_x, ctrl_y, ctrl_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_x_q  <= TRIG_RESET;
			trig_y_q  <= TRIG_RESET;
			trig_z_q  <= TRIG_RESET;
			place_x_q <= PLACE_RESET;
			place_y_q <= PLACE_RESET;
			place_z_q <= PLACE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIG_X:  trig_x_q  <= cfg_data;
				REG_TRIG_Y:  trig_y_q  <= cfg_data;
				REG_TRIG_Z:  trig_z_q  <= cfg_data;
				REG_PLACE_X: place_x_q <= cfg_data;
				REG_PLACE_Y: place_y_q <= cfg_data;
				REG_PLACE_Z: place_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// register fields
	always_comb begin
		cx = $signed(trig_x_q[63:32]);
		sx = $signed(trig_x_q[31:0]);
		cy = $signed(trig_y_q[63:32]);
		sy = $signed(trig_y_q[31:0]);
		cz = $signed(trig_z_q[63:32]);
		sz = $signed(trig_z_q[31:0]);
		px = $signed(place_x_q[63:32]);
		tx = $signed(place_x_q[31:0]);
		py = $signed(place_y_q[63:32]);
		ty = $signed(place_y_q[31:0]);
		pz = $signed(place_z_q[63:32]);
		tz = $signed(place_z_q[31:0]);
	end

	// stage enables: a stage moves when it is empty or the one after it moves
	always_comb begin
		en[NSTAGE] = !vld_q[NSTAGE] || moved.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign pts.ready = en[1];

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= pts.valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// differences from the pivot for the x-axis rotation
	always_ff @(posedge clk) begin
		if (en[1]) begin
			dy_s1   <= 33'(pts.in_y) - 33'(py);
			dz_s1   <= 33'(pts.in_z) - 33'(pz);
			side_s1 <= {pts.last_point, pts.in_x};
		end
	end

	assign ctrl_x = '{en_mul: en[2], en_sum: en[3], en_sat: en[4]};

	// rotation about x: y and z move
	prt_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rot_x (
		.clk    (clk),
		.ctrl   (ctrl_x),
		.da     (dy_s1),
		.db     (dz_s1),
		.cos_k  (cx),
		.sin_k  (sx),
		.piv_a  (py),
		.piv_b  (pz),
		.side   (side_s1),
		.na     (ny_x),
		.nb     (nz_x),
		.side_o (side_x)
	);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			dx_s5   <= 33'($signed(side_x[31:0])) - 33'(px);
			dz_s5   <= 33'(nz_x) - 33'(pz);
			side_s5 <= {side_x[SIDE_W-1], ny_x};
		end
	end

	assign ctrl_y = '{en_mul: en[6], en_sum: en[7], en_sat: en[8]};

	// rotation about y: taken as z then x so the sign pattern matches
	prt_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rot_y (
		.clk    (clk),
		.ctrl   (ctrl_y),
		.da     (dz_s5),
		.db     (dx_s5),
		.cos_k  (cy),
		.sin_k  (sy),
		.piv_a  (pz),
		.piv_b  (px),
		.side   (side_s5),
		.na     (nz_y),
		.nb     (nx_y),
		.side_o (side_y)
	);

	always_ff @(posedge clk) begin
		if (en[9]) begin
			dx_s9   <= 33'(nx_y) - 33'(px);
			dy_s9   <= 33'($signed(side_y[31:0])) - 33'(py);
			side_s9 <= {side_y[SIDE_W-1], nz_y};
		end
	end

	assign ctrl_z = '{en_mul: en[10], en_sum: en[11], en_sat: en[12]};

	// rotation about z: x and y move
	prt_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rot_z (
		.clk    (clk),
		.ctrl   (ctrl_z),
		.da     (dx_s9),
		.db     (dy_s9),
		.cos_k  (cz),
		.sin_k  (sz),
		.piv_a  (px),
		.piv_b  (py),
		.side   (side_s9),
		.na     (nx_z),
		.nb     (ny_z),
		.side_o (side_z)
	);

	// translation by target minus pivot, into the output register
	always_ff @(posedge clk) begin
		if (en[13]) begin
			out_x_s13 <= sat_coord(38'(nx_z) + 38'(tx) - 38'(px), COORD_WIDTH);
			out_y_s13 <= sat_coord(38'(ny_z) + 38'(ty) - 38'(py), COORD_WIDTH);
			out_z_s13 <= sat_coord(38'($signed(side_z[31:0])) + 38'(tz) - 38'(pz),
				COORD_WIDTH);
			last_s13  <= side_z[SIDE_W-1];
		end
	end

	assign moved.valid    = vld_q[NSTAGE];
	assign moved.out_x    = out_x_s13;
	assign moved.out_y    = out_y_s13;
	assign moved.out_z    = out_z_s13;
	assign moved.out_last = last_s13;

`ifndef SYNTH
	// occupancy follows words in minus words out
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(vld_q) == $past($countones(vld_q))
			+ $past(int'(pts.valid && pts.ready))
			- $past(int'(moved.valid && moved.ready)))
		else $error("pipeline occupancy does not match handshakes");

	// a full pipeline with a stalled output takes nothing in
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && !moved.ready) |-> !pts.ready)
		else $error("input taken while pipeline full and stalled");

	// an empty pipeline always takes a word
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q == '0) |-> pts.ready)
		else $error("empty pipeline refuses input");
`endif

endmodule

// ===== hdl/prt_rotate.sv =====
// one plane rotation about a pivot: multiply, round, add pivot and saturate
module prt_rotate #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                         clk,
	input  prt_pkg::rot_ctrl_t           ctrl,
	input  logic signed [32:0]           da,
	input  logic signed [32:0]           db,
	input  logic signed [31:0]           cos_k,
	input  logic signed [31:0]           sin_k,
	input  logic signed [31:0]           piv_a,
	input  logic signed [31:0]           piv_b,
	input  logic [prt_pkg::SIDE_W-1:0]   side,
	output logic signed [31:0]           na,
	output logic signed [31:0]           nb,
	output logic [prt_pkg::SIDE_W-1:0]   side_o
);
	import prt_pkg::*;

	localparam logic signed [65:0] RND = 66'sd1 <<< 29;

	logic signed [64:0] ac_s1, bs_s1, as_s1, bc_s1;
	logic signed [35:0] ra_s2, rb_s2;
	logic signed [31:0] na_s3, nb_s3;
	logic [SIDE_W-1:0]  side_s1, side_s2, side_s3;
	logic signed [65:0] sum_a, sum_b;

	// products of both differences with cosine and sine
	always_ff @(posedge clk) begin
		if (ctrl.en_mul) begin
			ac_s1   <= 65'(da) * 65'(cos_k);
			bs_s1   <= 65'(db) * 65'(sin_k);
			as_s1   <= 65'(da) * 65'(sin_k);
			bc_s1   <= 65'(db) * 65'(cos_k);
			side_s1 <= side;
		end
	end

	// combine and round to nearest, ties upwards
	always_comb begin
		sum_a = 66'(ac_s1) - 66'(bs_s1) + RND;
		sum_b = 66'(as_s1) + 66'(bc_s1) + RND;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_sum) begin
			ra_s2   <= sum_a[65:30];
			rb_s2   <= sum_b[65:30];
			side_s2 <= side_s1;
		end
	end

	// back onto the pivot, clamp to coordinate range
	always_ff @(posedge clk) begin
		if (ctrl.en_sat) begin
			na_s3   <= sat_coord(38'(ra_s2) + 38'(piv_a), COORD_WIDTH);
			nb_s3   <= sat_coord(38'(rb_s2) + 38'(piv_b), COORD_WIDTH);
			side_s3 <= side_s2;
		end
	end

	assign na     = na_s3;
	assign nb     = nb_s3;
	assign side_o = side_s3;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the point rotate and translate pipeline
module tb_top;
	import prt_pkg::*;

	localparam int unsigned COORD_W     = 32;
	localparam int unsigned TRIG_FRAC   = 30;
	localparam int          QUIET_LIMIT = 2000;
	localparam int          BLOCK_WORDS = 150;
	localparam int          PRINT_CAP   = 100;

	// indexes past the last register, writes to them must be ignored
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef logic signed [95:0] wide_t;

	localparam wide_t ROUND_HALF = 96'sh2000_0000;
	localparam wide_t COORD_HI   = (96'sd1 <<< (COORD_W - 1)) - 96'sd1;
	localparam wide_t COORD_LO   = -COORD_HI - 96'sd1;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        last;
	} moved_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// local copy of the register file
	logic [CFG_W-1:0] trig_word [3];
	logic [CFG_W-1:0] place_word [3];

	moved_t pending_moves [$];
	int error_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	prt_in_if  pts ();
	prt_out_if moved ();

	point_rotate_translate #(
		.COORD_WIDTH(COORD_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pts(pts),
		.moved(moved),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random back-pressure on the result side
	always @(posedge clk) begin
		moved.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	function automatic wide_t widen(input logic [31:0] v);
		wide_t w;
		w = $signed(v);
		return w;
	endfunction

	function automatic wide_t clamp(input wide_t v);
		if (v > COORD_HI) begin
			return COORD_HI;
		end else if (v < COORD_LO) begin
			return COORD_LO;
		end
		return v;
	endfunction

	// one rotated coordinate: round half up, add the pivot back, saturate
	function automatic wide_t spin(input wide_t da, input wide_t k1, input wide_t db,
			input wide_t k2, input wide_t pivot);
		wide_t acc;
		acc = da * k1 + db * k2 + ROUND_HALF;
		return clamp((acc >>> TRIG_FRAC) + pivot);
	endfunction

	function automatic moved_t move_point(input logic [31:0] ix, input logic [31:0] iy,
			input logic [31:0] iz, input logic last);
		wide_t x, y, z, nx, ny, nz, c, s, px, py, pz;
		moved_t r;
		px = widen(place_word[0][63:32]);
		py = widen(place_word[1][63:32]);
		pz = widen(place_word[2][63:32]);
		x = widen(ix);
		y = widen(iy);
		z = widen(iz);
		// about x
		c = widen(trig_word[0][63:32]);
		s = widen(trig_word[0][31:0]);
		ny = spin(y - py, c, z - pz, -s, py);
		nz = spin(y - py, s, z - pz, c, pz);
		y = ny;
		z = nz;
		// about y
		c = widen(trig_word[1][63:32]);
		s = widen(trig_word[1][31:0]);
		nx = spin(x - px, c, z - pz, s, px);
		nz = spin(x - px, -s, z - pz, c, pz);
		x = nx;
		z = nz;
		// about z
		c = widen(trig_word[2][63:32]);
		s = widen(trig_word[2][31:0]);
		nx = spin(x - px, c, y - py, -s, px);
		ny = spin(x - px, s, y - py, c, py);
		x = nx;
		y = ny;
		// move pivot onto target
		x = clamp(x + widen(place_word[0][31:0]) - px);
		y = clamp(y + widen(place_word[1][31:0]) - py);
		z = clamp(z + widen(place_word[2][31:0]) - pz);
		r.x = x[31:0];
		r.y = y[31:0];
		r.z = z[31:0];
		r.last = last;
		return r;
	endfunction

	function automatic logic [63:0] trig_pair(input logic [31:0] c, input logic [31:0] s);
		return {c, s};
	endfunction

	function automatic logic [63:0] place_pair(input logic [31:0] pivot,
			input logic [31:0] target);
		return {pivot, target};
	endfunction

	function automatic logic [63:0] unit_trig(input real ang);
		int c;
		int s;
		c = $rtoi($cos(ang) * 1073741824.0);
		s = $rtoi($sin(ang) * 1073741824.0);
		return trig_pair(c, s);
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0: begin
				return $urandom;
			end
			1: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				return $signed($urandom) >>> $urandom_range(4, 20);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin : check_moves
		moved_t want;
		if (arst_n && moved.valid === 1'b1 && moved.ready === 1'b1) begin
			if (pending_moves.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: %h %h %h %b",
					moved.out_x, moved.out_y, moved.out_z, moved.out_last));
			end else begin
				want = pending_moves.pop_front();
				if (moved.out_x !== want.x)
					report_mismatch($sformatf("out_x got %h want %h", moved.out_x, want.x));
				if (moved.out_y !== want.y)
					report_mismatch($sformatf("out_y got %h want %h", moved.out_y, want.y));
				if (moved.out_z !== want.z)
					report_mismatch($sformatf("out_z got %h want %h", moved.out_z, want.z));
				if (moved.out_last !== want.last)
					report_mismatch($sformatf("out_last got %b want %b", moved.out_last,
						want.last));
			end
		end
	end

	// ends the run if no word moves on either side for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pts.valid && pts.ready) || (moved.valid && moved.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// offer one point, random idle gaps first; valid stays up for the next word
	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			pts.valid <= 1'b0;
			@(posedge clk);
		end
		pts.valid      <= 1'b1;
		pts.in_x       <= x;
		pts.in_y       <= y;
		pts.in_z       <= z;
		pts.last_point <= last;
		@(posedge clk);
		while (pts.ready !== 1'b1) begin
			@(posedge clk);
		end
		pending_moves.push_back(move_point(x, y, z, last));
	endtask

	// stop sending and wait for every pending result
	task automatic drain_moves();
		pts.valid <= 1'b0;
		@(posedge clk);
		while (pending_moves.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_TRIG_X:  trig_word[0] = data;
			REG_TRIG_Y:  trig_word[1] = data;
			REG_TRIG_Z:  trig_word[2] = data;
			REG_PLACE_X: place_word[0] = data;
			REG_PLACE_Y: place_word[1] = data;
			REG_PLACE_Z: place_word[2] = data;
			default: ;
		endcase
	endtask

	task automatic cfg_release();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// full register set, only once the pipeline is empty
	task automatic configure(input logic [63:0] tx, input logic [63:0] ty,
			input logic [63:0] tz, input logic [63:0] plx, input logic [63:0] ply,
			input logic [63:0] plz);
		drain_moves();
		write_reg(REG_TRIG_X, tx);
		write_reg(REG_TRIG_Y, ty);
		write_reg(REG_TRIG_Z, tz);
		write_reg(REG_PLACE_X, plx);
		write_reg(REG_PLACE_Y, ply);
		write_reg(REG_PLACE_Z, plz);
		cfg_release();
	endtask

	task automatic pick_setting();
		logic [63:0] tw [3];
		logic [63:0] pw [3];
		for (int a = 0; a < 3; a++) begin
			case ($urandom_range(9))
				0: tw[a] = {$urandom, $urandom};
				1: tw[a] = TRIG_RESET;
				default: tw[a] = unit_trig($urandom_range(62831) / 10000.0);
			endcase
			if ($urandom_range(7) == 0) begin
				pw[a] = {$urandom, $urandom};
			end else begin
				pw[a] = place_pair($signed($urandom) >>> $urandom_range(8, 20),
					$signed($urandom) >>> $urandom_range(8, 20));
			end
		end
		configure(tw[0], tw[1], tw[2], pw[0], pw[1], pw[2]);
	endtask

	task automatic set_pacing(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	// reset registers give identity, so points pass through unchanged
	task automatic test_identity();
		send_point(32'h0, 32'h0, 32'h0, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
		send_point(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 1'b0);
	endtask

	// half scale about x: halfway values round towards plus infinity
	task automatic test_rounding();
		configure(trig_pair(32'h2000_0000, 32'h0), TRIG_RESET, TRIG_RESET,
			PLACE_RESET, PLACE_RESET, PLACE_RESET);
		send_point(32'h0, 32'h1, 32'hFFFF_FFFF, 1'b0);
		send_point(32'h0, 32'h3, 32'hFFFF_FFFD, 1'b1);
		send_point(32'h7, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
	endtask

	// extreme trig and placement words drive coordinates into saturation
	task automatic test_saturation();
		configure(trig_pair(32'h7FFF_FFFF, 32'h8000_0000),
			trig_pair(32'h8000_0000, 32'h7FFF_FFFF), {64{1'b1}},
			place_pair(32'h8000_0000, 32'h7FFF_FFFF),
			place_pair(32'h7FFF_FFFF, 32'h8000_0000), 64'h0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
		send_point(32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
	endtask

	// quarter turn about every axis around an off-origin pivot
	task automatic test_quarter_turns();
		configure(trig_pair(32'h0, 32'h4000_0000), trig_pair(32'h0, 32'h4000_0000),
			trig_pair(32'h0, 32'h4000_0000),
			place_pair(32'h0001_0000, 32'h0005_0000),
			place_pair(32'hFFFE_0000, 32'h0),
			place_pair(32'h0003_0000, 32'hFFF0_0000));
		send_point(32'h0002_0000, 32'h0, 32'h0, 1'b0);
		send_point(32'h0, 32'h0001_8000, 32'hFFFF_C000, 1'b1);
		send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
	endtask

	// writes beyond the last register leave the setting alone
	task automatic test_spare_index();
		configure(TRIG_RESET, 64'h0, TRIG_RESET,
			place_pair(32'h0000_8000, 32'hFFFF_8000),
			place_pair(32'h0010_0000, 32'h0),
			place_pair(32'h0, 32'h0020_0000));
		write_reg(REG_SPARE_LO, {64{1'b1}});
		write_reg(REG_SPARE_HI, {$urandom, $urandom});
		cfg_release();
		send_point(32'h0004_0000, 32'hFFFC_0000, 32'h0001_0000, 1'b0);
		send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
	endtask

	// random settings and points under every pacing profile
	task automatic test_random_streams();
		int tx_pct [4] = '{0, 49, 0, 20};
		int rx_pct [4] = '{0, 0, 49, 20};
		for (int p = 0; p < 4; p++) begin
			set_pacing(tx_pct[p], rx_pct[p]);
			for (int b = 0; b < 3; b++) begin
				pick_setting();
				for (int i = 0; i < BLOCK_WORDS; i++) begin
					// hold off mid-block until the pipeline has emptied
					if (i == BLOCK_WORDS / 2) begin
						drain_moves();
					end
					send_point(rand_coord(), rand_coord(), rand_coord(),
						$urandom_range(15) == 0);
				end
			end
		end
	endtask

	initial begin : run_tests
		pts.valid      <= 1'b0;
		pts.in_x       <= '0;
		pts.in_y       <= '0;
		pts.in_z       <= '0;
		pts.last_point <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_TRIG_X;
		cfg_data       <= '0;
		arst_n         <= 1'b0;
		for (int a = 0; a < 3; a++) begin
			trig_word[a] = TRIG_RESET;
			place_word[a] = PLACE_RESET;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_pacing(0, 0);
		test_identity();
		test_rounding();
		test_saturation();
		test_quarter_turns();
		test_spare_index();
		test_random_streams();
		drain_moves();
		repeat (NSTAGE + 8) @(posedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
